@@ design/pal_pkg.sv @@
`timescale 1ns / 1ps
package pal_pkg;

  localparam int CoordW = 16;
  localparam int SumW   = 40;
  localparam int SqW    = 2 * CoordW + 1;
  localparam int FracSh = 16;
  localparam int RadW   = SqW + 1 + FracSh;
  localparam int RootW  = RadW / 2;
  localparam int RemW   = RootW + 3;
  localparam int CntW   = $clog2(RootW);

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [CntW-1:0] CntLast = CntW'(RootW - 1);

  typedef struct packed {
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
  } seg_pts_t;

  typedef enum logic [1:0] {
    SEG_IDLE,
    SEG_SQX,
    SEG_SQY,
    SEG_ROOT
  } seg_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_A,
    ST_START_B,
    ST_RUN_B,
    ST_EMIT
  } top_state_e;

endpackage

@@ design/pal_if.sv @@
`timescale 1ns / 1ps
interface pal_pt_if;
  import pal_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] point_x;
  logic [CoordW-1:0] point_y;
  logic              is_last;
  modport source (output valid, point_x, point_y, is_last, input ready);
  modport sink   (input valid, point_x, point_y, is_last, output ready);
endinterface

interface pal_len_if;
  import pal_pkg::*;
  logic            valid;
  logic            ready;
  logic [SumW-1:0] total_length;
  logic            saturated;
  modport source (output valid, total_length, saturated, input ready);
  modport sink   (input valid, total_length, saturated, output ready);
endinterface

interface pal_cfg_if;
  logic valid;
  logic ready;
  logic closed_loop;
  modport source (output valid, closed_loop, input ready);
  modport sink   (input valid, closed_loop, output ready);
endinterface

@@ design/pal_seg_unit.sv @@
`timescale 1ns / 1ps
module pal_seg_unit
  import pal_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  seg_pts_t         pts_i,
  output logic             done_o,
  output logic [RootW-1:0] len_o
);

  seg_state_e        state_q, state_d;
  logic [CoordW-1:0] ux_q, uy_q;
  logic [SqW-1:0]    sq_q;
  logic [RadW-1:0]   rad_q;
  logic [RootW-1:0]  root_q;
  logic [RemW-1:0]   rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              done_q;

  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]        ndx, ndy;
  logic [CoordW-1:0]      mul_op;
  logic [SqW-1:0]         prod;
  logic [SqW:0]           sq_sum;
  logic [RemW-1:0]        rem_sh, trial;
  logic                   fits;

  assign dx  = $signed({pts_i.ax[CoordW-1], pts_i.ax}) - $signed({pts_i.bx[CoordW-1], pts_i.bx});
  assign dy  = $signed({pts_i.ay[CoordW-1], pts_i.ay}) - $signed({pts_i.by[CoordW-1], pts_i.by});
  assign ndx = -dx;
  assign ndy = -dy;

  // one multiplier, shared between the two squares
  assign mul_op = (state_q == SEG_SQX) ? ux_q : uy_q;
  assign prod   = SqW'({16'd0, mul_op} * {16'd0, mul_op});
  assign sq_sum = {1'b0, sq_q} + {1'b0, prod};

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SEG_ROOT) && (cnt_q == CntLast);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEG_IDLE: if (start_i) state_d = SEG_SQX;
      SEG_SQX:  state_d = SEG_SQY;
      SEG_SQY:  state_d = SEG_ROOT;
      SEG_ROOT: if (cnt_q == CntLast) state_d = SEG_IDLE;
      default:  state_d = SEG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SEG_IDLE: begin
        if (start_i) begin
          ux_q <= dx[CoordW] ? ndx[CoordW-1:0] : dx[CoordW-1:0];
          uy_q <= dy[CoordW] ? ndy[CoordW-1:0] : dy[CoordW-1:0];
        end
      end
      SEG_SQX: sq_q <= prod;
      SEG_SQY: begin
        rad_q  <= {sq_sum, {FracSh{1'b0}}};
        root_q <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      SEG_ROOT: begin
        rad_q <= rad_q << 2;
        cnt_q <= cnt_q + 1'b1;
        if (fits) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign len_o  = root_q;

endmodule

@@ design/polyline_arc_length_top.sv @@
`timescale 1ns / 1ps
// The first point of a contour is taken at once; every later point waits for the
//   shared bit-serial square root (two squares on one multiplier, a 25-bit root, accumulate).
// After the last point the result is loaded for out_o; a closed loop first adds the closing segment.
// The result beat waits in ST_EMIT while an earlier result on out_o is stalled.
// Reset (rst_ni, async, active low): open polyline mode, empty contour, no result pending.
module polyline_arc_length_top
  import pal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pal_pt_if.sink    in_i,
  pal_len_if.source out_o,
  pal_cfg_if.sink   cfg_i
);

  top_state_e        state_q, state_d;
  logic              closed_q;
  logic              have_q;
  logic              last_q;
  logic              sat_q;
  logic [SumW-1:0]   sum_q;
  logic [CoordW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic              out_valid_q;
  logic [SumW-1:0]   out_len_q;
  logic              out_sat_q;

  logic             accept, seg_start, seg_done, emit;
  logic [RootW-1:0] seg_len;
  seg_pts_t         pts;
  logic [SumW:0]    sum_ext;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign emit        = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign seg_start   = (accept && have_q) || (state_q == ST_START_B);

  always_comb begin
    if (state_q == ST_START_B) begin
      pts = '{ax: first_x_q, ay: first_y_q, bx: prev_x_q, by: prev_y_q};
    end else begin
      pts = '{ax: in_i.point_x, ay: in_i.point_y, bx: prev_x_q, by: prev_y_q};
    end
  end

  pal_seg_unit u_seg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(seg_start),
    .pts_i  (pts),
    .done_o (seg_done),
    .len_o  (seg_len)
  );

  assign sum_ext = {1'b0, sum_q} + {{(SumW + 1 - RootW){1'b0}}, seg_len};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (have_q) state_d = ST_RUN_A;
          else if (in_i.is_last) state_d = closed_q ? ST_START_B : ST_EMIT;
        end
      end
      ST_RUN_A: begin
        if (seg_done) begin
          if (!last_q) state_d = ST_IDLE;
          else state_d = closed_q ? ST_START_B : ST_EMIT;
        end
      end
      ST_START_B: state_d = ST_RUN_B;
      ST_RUN_B:   if (seg_done) state_d = ST_EMIT;
      ST_EMIT:    if (emit) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      closed_q    <= 1'b0;
      have_q      <= 1'b0;
      last_q      <= 1'b0;
      sat_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) closed_q <= cfg_i.closed_loop;
      if (accept) begin
        have_q <= 1'b1;
        last_q <= in_i.is_last;
      end
      if (seg_done) begin
        if (sum_ext >= {1'b0, SumMax}) begin
          sum_q <= SumMax;
          sat_q <= 1'b1;
        end else begin
          sum_q <= sum_ext[SumW-1:0];
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        have_q      <= 1'b0;
        sat_q       <= 1'b0;
        sum_q       <= '0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_x_q <= in_i.point_x;
      prev_y_q <= in_i.point_y;
      if (!have_q) begin
        first_x_q <= in_i.point_x;
        first_y_q <= in_i.point_y;
      end
    end
    if (emit) begin
      out_len_q <= sum_q;
      out_sat_q <= sat_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.total_length = out_len_q;
  assign out_o.saturated    = out_sat_q;

endmodule

@@ design/pal_checker.sv @@
`timescale 1ns / 1ps
module pal_checker
  import pal_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  pal_pt_if.sink    in_i,
  pal_len_if.source out_o,
  pal_cfg_if.sink   cfg_i
);

  default disable iff (!rst_ni);

  a_out_hold: assert property (@(posedge clk_i)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.total_length)
      && $stable(out_o.saturated))
    else $error("result beat dropped or changed while stalled");

  a_sat_max: assert property (@(posedge clk_i)
    out_o.valid && out_o.saturated |-> out_o.total_length == SumMax)
    else $error("saturated result below maximum");

  a_rose_busy: assert property (@(posedge clk_i)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result appeared while input side idle");

  a_no_early: assert property (@(posedge clk_i)
    in_i.valid && in_i.ready && !in_i.is_last |=> !$rose(out_o.valid))
    else $error("result without a last point");

  a_cfg_rdy: assert property (@(posedge clk_i) cfg_i.ready)
    else $error("config port not ready");

endmodule

bind polyline_arc_length_top pal_checker u_pal_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench
  import pal_pkg::*;
();

  localparam int ClockHalf   = 10;
  localparam int ResetCycles = 11;
  localparam int DrainCycles = 64;
  localparam int HoldCycles  = 600;
  localparam int RandomItems = 700;
  localparam int CycleLimit  = 4000000;
  localparam int MaxReports  = 40;

  typedef enum logic {
    ROW_POINT,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
    logic              fixed;
    logic [SumW-1:0]   total;
    logic              sat;
  } script_row_t;

  typedef struct packed {
    logic [SumW-1:0] total;
    logic            sat;
  } contour_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pal_pt_if  pt_if ();
  pal_len_if len_if ();
  pal_cfg_if cfg_if ();

  polyline_arc_length_top u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (pt_if),
    .out_o (len_if),
    .cfg_i (cfg_if)
  );

  always begin
    #ClockHalf clk = 1'b1;
    #ClockHalf clk = 1'b0;
  end

  // known result riding along with the beat, for rows with a typed-in answer
  logic            known_valid;
  logic [SumW-1:0] known_total;
  logic            known_sat;

  // contour tracker state
  logic              loop_mode;
  logic [CoordW-1:0] first_x, first_y, prev_x, prev_y;
  logic [SumW-1:0]   len_acc;
  logic              have_pt;
  logic              sat_flag;

  contour_result_t expected_lengths[$];
  script_row_t     script[$];
  int              mismatches = 0;
  int              cycles = 0;
  logic            hold_req = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 26; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [SumW-1:0] seg_length(logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
                                                 logic [CoordW-1:0] bx, logic [CoordW-1:0] by);
    longint dx;
    longint dy;
    dx = longint'($signed(ax)) - longint'($signed(bx));
    dy = longint'($signed(ay)) - longint'($signed(by));
    return SumW'(int_sqrt(64'((dx * dx + dy * dy) << FracSh)));
  endfunction

  task automatic add_length(logic [SumW-1:0] d);
    logic [SumW:0] s;
    s = {1'b0, len_acc} + {1'b0, d};
    if (s >= {1'b0, SumMax}) begin
      len_acc  = SumMax;
      sat_flag = 1'b1;
    end else begin
      len_acc = s[SumW-1:0];
    end
  endtask

  task automatic clear_contour();
    first_x  = '0;
    first_y  = '0;
    prev_x   = '0;
    prev_y   = '0;
    len_acc  = '0;
    have_pt  = 1'b0;
    sat_flag = 1'b0;
  endtask

  task automatic trace_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic last);
    contour_result_t res;
    if (!have_pt) begin
      first_x = x;
      first_y = y;
      have_pt = 1'b1;
    end else begin
      add_length(seg_length(x, y, prev_x, prev_y));
    end
    prev_x = x;
    prev_y = y;
    if (last) begin
      if (loop_mode) add_length(seg_length(first_x, first_y, x, y));
      res.total = len_acc;
      res.sat   = sat_flag;
      if (known_valid) begin
        res.total = known_total;
        res.sat   = known_sat;
      end
      expected_lengths.push_back(res);
      clear_contour();
    end
  endtask

  initial begin
    loop_mode = 1'b0;
    clear_contour();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) loop_mode = cfg_if.closed_loop;
      if (pt_if.valid && pt_if.ready) trace_point(pt_if.point_x, pt_if.point_y, pt_if.is_last);
    end
  end

  task automatic flag_mismatch(string what, logic [SumW-1:0] got, logic [SumW-1:0] want);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : check
    contour_result_t want;
    if (rst_n && len_if.valid && len_if.ready) begin
      if (expected_lengths.size() == 0) begin
        flag_mismatch("unexpected beat, total_length", len_if.total_length, '0);
      end else begin
        want = expected_lengths.pop_front();
        if (len_if.total_length !== want.total)
          flag_mismatch("total_length", len_if.total_length, want.total);
        if (len_if.saturated !== want.sat)
          flag_mismatch("saturated", SumW'(len_if.saturated), SumW'(want.sat));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 30);
    return $urandom_range(31, 90);
  endfunction

  function automatic int sender_gap();
    if ($urandom_range(0, 99) < 35) return 0;
    return idle_len();
  endfunction

  function automatic logic [CoordW-1:0] next_coord(logic [CoordW-1:0] from);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return from + CoordW'($urandom_range(0, 1023)) - CoordW'(512);
    if (r < 75) return CoordW'($urandom);
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return from;
  endfunction

  // receiver: random stalls, steady stretches, and long hold-offs on request
  initial begin : receiver
    int r;
    len_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        len_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          len_if.ready <= 1'b1;
          repeat ($urandom_range(50, 300)) @(posedge clk);
        end else if (r < 70) begin
          len_if.ready <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
          len_if.ready <= 1'b0;
          repeat (idle_len()) @(posedge clk);
        end
      end
    end
  end

  task automatic send_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic last, int gap,
                            logic fixed, logic [SumW-1:0] total, logic sat);
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    pt_if.is_last <= last;
    known_valid   <= fixed;
    known_total   <= total;
    known_sat     <= sat;
    do @(posedge clk); while (!pt_if.ready);
  endtask

  task automatic wait_idle();
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_loop_mode(logic mode);
    cfg_if.valid       <= 1'b1;
    cfg_if.closed_loop <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic plan_point(int x, int y, logic last, logic fixed, longint total);
    script_row_t row;
    row.kind  = ROW_POINT;
    row.x     = CoordW'(x);
    row.y     = CoordW'(y);
    row.last  = last;
    row.fixed = fixed;
    row.total = SumW'(total);
    row.sat   = 1'b0;
    script.push_back(row);
  endtask

  task automatic plan_config(logic mode);
    script_row_t row;
    row      = '0;
    row.kind = ROW_CONFIG;
    row.x    = CoordW'(mode);
    script.push_back(row);
  endtask

  initial begin : stimulus
    logic [CoordW-1:0] cx, cy;
    int sent, contour, npts, split, r;
    bit tight;

    rst_n              <= 1'b0;
    pt_if.valid        <= 1'b0;
    pt_if.point_x      <= '0;
    pt_if.point_y      <= '0;
    pt_if.is_last      <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.closed_loop <= 1'b0;
    known_valid        <= 1'b0;
    known_total        <= '0;
    known_sat          <= 1'b0;

    // open polyline, straight after reset
    plan_point(0, 0, 1, 1, 0);
    plan_point(-32768, 0, 0, 0, 0);
    plan_point(32767, 0, 1, 1, 16776960);
    plan_point(0, -32768, 0, 0, 0);
    plan_point(0, 32767, 1, 1, 16776960);
    plan_point(-32768, -32768, 0, 0, 0);
    plan_point(32767, 32767, 0, 0, 0);
    plan_point(-32768, 32767, 0, 0, 0);
    plan_point(32767, -32768, 1, 0, 0);
    plan_point(0, 0, 0, 0, 0);
    plan_point(16, 0, 0, 0, 0);
    plan_point(16, 16, 0, 0, 0);
    plan_point(0, 16, 1, 1, 12288);
    // closed loop
    plan_config(1);
    plan_point(5, 5, 1, 1, 0);
    plan_point(0, 0, 0, 0, 0);
    plan_point(16, 0, 0, 0, 0);
    plan_point(16, 16, 0, 0, 0);
    plan_point(0, 16, 1, 1, 16384);
    plan_point(-32768, -32768, 0, 0, 0);
    plan_point(32767, 32767, 1, 0, 0);
    // mode switched in the middle of a contour
    plan_point(1234, -77, 0, 0, 0);
    plan_point(-1, -1, 0, 0, 0);
    plan_config(0);
    plan_point(300, 200, 1, 0, 0);
    plan_point(7, 7, 0, 0, 0);
    plan_point(100, -9, 0, 0, 0);
    plan_config(1);
    plan_point(-5, 3, 1, 0, 0);

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG) begin
        wait_idle();
        write_loop_mode(script[i].x[0]);
      end else begin
        send_point(script[i].x, script[i].y, script[i].last, sender_gap(),
                   script[i].fixed, script[i].total, script[i].sat);
      end
    end

    cx      = '0;
    cy      = '0;
    sent    = 0;
    contour = 0;
    while (sent < RandomItems) begin
      if (contour == 30 || contour == 110) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 12) begin
        wait_idle();
        write_loop_mode(1'($urandom_range(0, 1)));
      end
      r = $urandom_range(0, 99);
      if (r < 10) npts = 1;
      else if (r < 85) npts = $urandom_range(2, 8);
      else npts = $urandom_range(9, 30);
      tight = ($urandom_range(0, 3) == 0);
      split = ($urandom_range(0, 19) == 0 && npts >= 3) ? npts / 2 : -1;
      for (int k = 0; k < npts; k++) begin
        if (k == split) begin
          wait_idle();
          write_loop_mode(1'($urandom_range(0, 1)));
        end
        cx = next_coord(cx);
        cy = next_coord(cy);
        send_point(cx, cy, k == npts - 1, tight ? 0 : sender_gap(), 1'b0, '0, 1'b0);
        sent++;
      end
      contour++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
